/* rtl/core/sfrs_pkg.sv */
// ----------------------------------------------------------------------------
// sfrs_pkg
// Shared types and constants of the shape fill row span generator.
// ----------------------------------------------------------------------------
package sfrs_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ROW_PITCH     = 3'd2;
    localparam logic [2:0] REG_RED_POS       = 3'd3;
    localparam logic [2:0] REG_GREEN_POS     = 3'd4;
    localparam logic [2:0] REG_BLUE_POS      = 3'd5;

    // Shape kinds.
    localparam logic OP_RECT   = 1'b0;
    localparam logic OP_CIRCLE = 1'b1;

    // Width of the internal signed coordinate arithmetic.
    localparam int CW = 18;
    // Radius bits, squared bits.
    localparam int RW = 15;
    localparam int SQW = 2 * RW;

    // Item context carried alongside the square root.
    typedef struct packed {
        logic                 op;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] y;
        logic [RW-1:0]        ex;
        logic                 rect_in;
        logic signed [CW-1:0] rect_xs;
        logic signed [CW-1:0] rect_xe;
        logic                 circ_in;
        logic [31:0]          pix;
    } tag_t;

endpackage

/* rtl/core/sfrs_if.sv */
// ----------------------------------------------------------------------------
// sfrs_if
// Channel interfaces: shape requests, span results and register writes.
// ----------------------------------------------------------------------------
interface sfrs_shape_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [14:0]        extent_x;
    logic [14:0]        extent_y;
    logic signed [15:0] row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    modport source (output valid, opcode, center_x, center_y, extent_x, extent_y,
                    row, red, green, blue, input ready);
    modport sink   (input valid, opcode, center_x, center_y, extent_x, extent_y,
                    row, red, green, blue, output ready);
endinterface

interface sfrs_span_if;
    logic        valid;
    logic        ready;
    logic        span_valid;
    logic [25:0] start_address;
    logic [12:0] span_length;
    logic [31:0] pixel_word;

    modport source (output valid, span_valid, start_address, span_length, pixel_word,
                    input ready);
    modport sink   (input valid, span_valid, start_address, span_length, pixel_word,
                    output ready);
endinterface

interface sfrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/shape_fill_row_span_generator_core.sv */
// ----------------------------------------------------------------------------
// shape_fill_row_span_generator_core
// Register path: stages 0, 1, 2, the root cells, stage F1, output register.
// Throughput: one span per cycle; the pipeline moves as a whole and stalls
// only while the output register holds a beat that is not taken.
// The root is found by a chain of 15 cells, one root bit each.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module shape_fill_row_span_generator_core #(
    parameter int COORD_BITS = 16,
    parameter int MAX_SCREEN = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    sfrs_shape_if.sink     shape_in,
    sfrs_span_if.source    span_out,
    sfrs_cfg_if.sink       cfg
);

    localparam int CW  = sfrs_pkg::CW;
    localparam int RW  = sfrs_pkg::RW;
    localparam int SQW = sfrs_pkg::SQW;
    localparam int SB  = $clog2(MAX_SCREEN + 1);

    // Configuration registers.
    logic [12:0] width_reg, height_reg;
    logic [15:0] pitch_reg;
    logic [4:0]  rpos_reg, gpos_reg, bpos_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            pitch_reg  <= 16'd2560;
            rpos_reg   <= 5'd16;
            gpos_reg   <= 5'd8;
            bpos_reg   <= 5'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sfrs_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg.data[12:0];
                sfrs_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg.data[12:0];
                sfrs_pkg::REG_ROW_PITCH:     pitch_reg  <= cfg.data;
                sfrs_pkg::REG_RED_POS:       rpos_reg   <= cfg.data[4:0];
                sfrs_pkg::REG_GREEN_POS:     gpos_reg   <= cfg.data[4:0];
                sfrs_pkg::REG_BLUE_POS:      bpos_reg   <= cfg.data[4:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything moves unless the output beat is held.
    logic out_valid_reg;
    logic adv;
    assign adv            = !out_valid_reg || span_out.ready;
    assign shape_in.ready = adv;

    // Front end: coordinates, rectangle span, circle row test and pixel word.
    logic signed [COORD_BITS-1:0] cx_n, cy_n, y_n;
    logic signed [CW-1:0] cx, cy, yy, ext, hx, hy, dy, dy_abs;
    sfrs_pkg::tag_t tag0;

    always_comb
    begin
        cx_n = shape_in.center_x[COORD_BITS-1:0];
        cy_n = shape_in.center_y[COORD_BITS-1:0];
        y_n  = shape_in.row[COORD_BITS-1:0];
        cx   = CW'(cx_n);
        cy   = CW'(cy_n);
        yy   = CW'(y_n);
        ext  = CW'({1'b0, shape_in.extent_x});
        hx   = CW'({1'b0, shape_in.extent_x[RW-1:1]});
        hy   = CW'({1'b0, shape_in.extent_y[RW-1:1]});
        dy   = yy - cy;
        dy_abs = dy[CW-1] ? -dy : dy;
        tag0.op      = shape_in.opcode;
        tag0.cx      = cx;
        tag0.y       = yy;
        tag0.ex      = shape_in.extent_x;
        tag0.rect_in = (yy >= cy - hy) && (yy < cy + hy);
        tag0.rect_xs = cx - hx;
        tag0.rect_xe = cx + hx;
        tag0.circ_in = (yy >= cy - ext) && (yy < cy + ext);
        tag0.pix     = (32'(shape_in.blue)  << bpos_reg)
                     | (32'(shape_in.green) << gpos_reg)
                     | (32'(shape_in.red)   << rpos_reg);
    end

    // Stage 0: registered front end.
    logic           v0_reg;
    sfrs_pkg::tag_t t0_reg;
    logic [RW-1:0]  dy0_reg;

    // Stage 1: squares.
    logic           v1_reg;
    sfrs_pkg::tag_t t1_reg;
    logic [SQW-1:0] exsq_reg, dysq_reg;

    // Stage 2: radicand.
    logic           v2_reg;
    sfrs_pkg::tag_t t2_reg;
    logic [SQW-1:0] rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= shape_in.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg   <= tag0;
            dy0_reg  <= dy_abs[RW-1:0];
            t1_reg   <= t0_reg;
            exsq_reg <= t0_reg.ex * t0_reg.ex;
            dysq_reg <= dy0_reg * dy0_reg;
            t2_reg   <= t1_reg;
            rad_reg  <= t1_reg.circ_in ? exsq_reg - dysq_reg : '0;
        end
    end

    // Square root chain, most significant root bit first.
    logic           cv   [RW+1];
    logic [SQW-1:0] crem [RW+1];
    logic [RW-1:0]  croot[RW+1];
    sfrs_pkg::tag_t ctag [RW+1];

    assign cv[0]    = v2_reg;
    assign crem[0]  = rad_reg;
    assign croot[0] = '0;
    assign ctag[0]  = t2_reg;

    for (genvar k = 0; k < RW; k++)
    begin : g_cell
        sfrs_sqrt_cell #(.BIT(RW - 1 - k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (cv[k]),
            .rem_in    (crem[k]),
            .root_in   (croot[k]),
            .tag_in    (ctag[k]),
            .valid_out (cv[k+1]),
            .rem_out   (crem[k+1]),
            .root_out  (croot[k+1]),
            .tag_out   (ctag[k+1])
        );
    end

    // Span end points, clipping and visibility.
    sfrs_pkg::tag_t  tf;
    logic [RW:0]     m1, lim;
    logic signed [CW:0] xs, xe, wlim, hlim;
    logic            covered, vis;

    always_comb
    begin
        tf  = ctag[RW];
        m1  = {1'b0, croot[RW]} + (RW+1)'(1);
        lim = (m1 < {1'b0, tf.ex}) ? m1 : {1'b0, tf.ex};
        wlim = ({1'b0, width_reg} > 14'(MAX_SCREEN)) ? (CW+1)'(MAX_SCREEN)
                                                      : (CW+1)'(width_reg);
        hlim = ({1'b0, height_reg} > 14'(MAX_SCREEN)) ? (CW+1)'(MAX_SCREEN)
                                                       : (CW+1)'(height_reg);
        if (tf.op == sfrs_pkg::OP_RECT)
        begin
            covered = tf.rect_in;
            xs      = (CW+1)'(tf.rect_xs);
            xe      = (CW+1)'(tf.rect_xe);
        end
        else
        begin
            covered = tf.circ_in;
            xs      = (CW+1)'(tf.cx) - (CW+1)'({1'b0, croot[RW]});
            xe      = (CW+1)'(tf.cx) + (CW+1)'(lim);
        end
        if (xs < 0)
            xs = '0;
        if (xe > wlim)
            xe = wlim;
        vis = covered && (tf.y >= 0) && ((CW+1)'(tf.y) < hlim) && (xs < xe);
    end

    // Stage F1: row address product.
    logic        f1v_reg, f1vis_reg;
    logic [SB-1:0] f1xs_reg;
    logic [SB:0]   f1len_reg;
    logic [SB+15:0] f1prod_reg;
    logic [31:0]   f1pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1v_reg <= 1'b0;
        else if (adv)
            f1v_reg <= cv[RW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1vis_reg  <= vis;
            f1xs_reg   <= xs[SB-1:0];
            f1len_reg  <= (SB+1)'(xe - xs);
            f1prod_reg <= tf.y[SB-1:0] * pitch_reg;
            f1pix_reg  <= tf.pix;
        end
    end

    // Output register.
    logic        osv_reg;
    logic [25:0] oaddr_reg;
    logic [12:0] olen_reg;
    logic [31:0] opix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= f1v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            osv_reg   <= f1vis_reg;
            oaddr_reg <= f1vis_reg ? 26'((f1prod_reg >> 2) + (SB+16)'(f1xs_reg)) : '0;
            olen_reg  <= f1vis_reg ? 13'(f1len_reg) : '0;
            opix_reg  <= f1vis_reg ? f1pix_reg : '0;
        end
    end

    assign span_out.valid         = out_valid_reg;
    assign span_out.span_valid    = osv_reg;
    assign span_out.start_address = oaddr_reg;
    assign span_out.span_length   = olen_reg;
    assign span_out.pixel_word    = opix_reg;

endmodule

/* rtl/core/sfrs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// sfrs_sqrt_cell
// One cell of the square root chain: decides one root bit per beat.
// ----------------------------------------------------------------------------
module sfrs_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      valid_in,
    input  logic [sfrs_pkg::SQW-1:0]  rem_in,
    input  logic [sfrs_pkg::RW-1:0]   root_in,
    input  sfrs_pkg::tag_t            tag_in,
    output logic                      valid_out,
    output logic [sfrs_pkg::SQW-1:0]  rem_out,
    output logic [sfrs_pkg::RW-1:0]   root_out,
    output sfrs_pkg::tag_t            tag_out
);

    logic [sfrs_pkg::SQW:0] trial;
    logic                   take;
    logic                   valid_reg;
    logic [sfrs_pkg::SQW-1:0] rem_reg;
    logic [sfrs_pkg::RW-1:0]  root_reg;
    sfrs_pkg::tag_t           tag_reg;

    // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT).
    assign trial = ((sfrs_pkg::SQW+1)'(root_in) << (BIT + 1))
                 | ((sfrs_pkg::SQW+1)'(1) << (2 * BIT));
    assign take  = {1'b0, rem_in} >= trial;

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    // Data.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= take ? sfrs_pkg::SQW'({1'b0, rem_in} - trial) : rem_in;
            root_reg <= take ? (root_in | (sfrs_pkg::RW'(1) << BIT)) : root_in;
            tag_reg  <= tag_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign tag_out   = tag_reg;

endmodule

/* dv/shape_fill_row_span_generator_core_tb.sv */
// ----------------------------------------------------------------------------
// shape_fill_row_span_generator_core_tb
// Self-checking bench for the shape fill row span generator.
// A burst driver offers rectangle and circle row requests. A monitor predicts
// each clipped span when its request beat is taken and compares every span
// beat against the oldest prediction. Register settings change between
// phases, while the block is idle.
// ----------------------------------------------------------------------------
module shape_fill_row_span_generator_core_tb;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [14:0]        extent_x;
        logic [14:0]        extent_y;
        logic signed [15:0] row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } shape_req_t;

    typedef struct packed {
        logic        span_valid;
        logic [25:0] start_address;
        logic [12:0] span_length;
        logic [31:0] pixel_word;
    } span_t;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 300;

    logic clk;
    logic rst_n;

    sfrs_shape_if shape_bus ();
    sfrs_span_if  span_bus ();
    sfrs_cfg_if   cfg_bus ();

    shape_fill_row_span_generator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .shape_in (shape_bus),
        .span_out (span_bus),
        .cfg      (cfg_bus)
    );

    // Register copies seen by the span predictor.
    logic [12:0] scr_w;
    logic [12:0] scr_h;
    logic [15:0] pitch;
    logic [4:0]  red_sh;
    logic [4:0]  green_sh;
    logic [4:0]  blue_sh;

    shape_req_t pending_shapes[$];
    span_t      expected_spans[$];
    int         errors;
    int         shapes_sent;
    int         spans_seen;
    int         filled_spans;
    int         cfg_writes;
    int         idle_cycles;
    logic       shape_taken;
    logic       hold_req;

    // Clock.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Integer square root, one result bit per step from the top.
    function automatic longint root_floor(longint v);
        longint acc;
        longint t;
        acc = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = acc | (longint'(1) << b);
            if (t * t <= v)
                acc = t;
        end
        return acc;
    endfunction

    // Clipped span that a shape covers on its row.
    function automatic span_t row_span(shape_req_t s);
        span_t  res;
        longint cx, cy, ex, ey, y, w, h, xs, xe, hx, hy, dy, m;
        logic   hit;
        logic [31:0] pix;
        cx = s.center_x;
        cy = s.center_y;
        ex = s.extent_x;
        ey = s.extent_y;
        y  = s.row;
        w  = (scr_w > 13'd4096) ? 4096 : scr_w;
        h  = (scr_h > 13'd4096) ? 4096 : scr_h;
        hit = 1'b0;
        xs = 0;
        xe = 0;
        if (s.opcode == sfrs_pkg::OP_RECT)
        begin
            hx = ex / 2;
            hy = ey / 2;
            if (y >= cy - hy && y < cy + hy)
            begin
                hit = 1'b1;
                xs = cx - hx;
                xe = cx + hx;
            end
        end
        else if (y >= cy - ex && y < cy + ex)
        begin
            dy = y - cy;
            m = root_floor(ex * ex - dy * dy);
            hit = 1'b1;
            xs = cx - m;
            xe = cx + ((m + 1 < ex) ? m + 1 : ex);
        end
        if (xs < 0)
            xs = 0;
        if (xe > w)
            xe = w;
        res = '0;
        if (hit && y >= 0 && y < h && xs < xe)
        begin
            pix = ({24'd0, s.blue} << blue_sh) | ({24'd0, s.green} << green_sh)
                | ({24'd0, s.red} << red_sh);
            res.span_valid    = 1'b1;
            res.start_address = 26'((y * longint'(pitch)) / 4 + xs);
            res.span_length   = 13'(xe - xs);
            res.pixel_word    = pix;
        end
        return res;
    endfunction

    // Random request, mostly aimed at the visible area with small sizes.
    function automatic shape_req_t random_shape();
        shape_req_t s;
        int w, cx, ex;
        w = (scr_w > 13'd4096) ? 4096 : int'(scr_w);
        s.opcode = 1'($urandom_range(0, 1));
        s.red    = 8'($urandom);
        s.green  = 8'($urandom);
        s.blue   = 8'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            s.center_x = 16'($urandom);
            s.center_y = 16'($urandom);
            s.extent_x = 15'($urandom);
            s.extent_y = 15'($urandom);
            s.row      = ($urandom_range(0, 1) != 0) ? 16'($urandom) : s.center_y;
        end
        else
        begin
            cx = $urandom_range(0, w + 64) - 32;
            ex = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6000)
                                             : $urandom_range(0, 40);
            s.center_x = 16'(cx);
            s.center_y = 16'($urandom_range(0, 600) - 40);
            s.extent_x = 15'(ex);
            s.extent_y = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 6000))
                                                     : 15'($urandom_range(0, 40));
            s.row = 16'(int'(s.center_y) + $urandom_range(0, 2 * ex + 4) - ex - 2);
        end
        return s;
    endfunction

    function automatic shape_req_t mk(logic op, int cx, int cy, int ex, int ey, int y,
                                      int r, int g, int b);
        shape_req_t s;
        s.opcode = op;
        s.center_x = 16'(cx);
        s.center_y = 16'(cy);
        s.extent_x = 15'(ex);
        s.extent_y = 15'(ey);
        s.row = 16'(y);
        s.red = 8'(r);
        s.green = 8'(g);
        s.blue = 8'(b);
        return s;
    endfunction

    // Shape driver: bursts of beats with random gaps between them.
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            shape_bus.valid    <= 1'b0;
            shape_bus.opcode   <= sfrs_pkg::OP_RECT;
            shape_bus.center_x <= '0;
            shape_bus.center_y <= '0;
            shape_bus.extent_x <= '0;
            shape_bus.extent_y <= '0;
            shape_bus.row      <= '0;
            shape_bus.red      <= '0;
            shape_bus.green    <= '0;
            shape_bus.blue     <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!shape_bus.valid || shape_taken)
        begin
            if (gap_left > 0 || pending_shapes.size() == 0)
            begin
                shape_bus.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                shape_req_t s;
                s = pending_shapes.pop_front();
                shape_bus.valid    <= 1'b1;
                shape_bus.opcode   <= s.opcode;
                shape_bus.center_x <= s.center_x;
                shape_bus.center_y <= s.center_y;
                shape_bus.extent_x <= s.extent_x;
                shape_bus.extent_y <= s.extent_y;
                shape_bus.row      <= s.row;
                shape_bus.red      <= s.red;
                shape_bus.green    <= s.green;
                shape_bus.blue     <= s.blue;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Span receiver: alternates free-running and stalling stretches, plus one
    // long hold-off when requested.
    int hold_left;
    int mode_left;
    logic choppy;
    logic hold_done;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            span_bus.ready <= 1'b0;
            hold_left <= 0;
            mode_left <= 0;
            choppy <= 1'b0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            span_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            span_bus.ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left <= $urandom_range(10, 80);
                choppy <= 1'($urandom_range(0, 1));
            end
            else
                mode_left <= mode_left - 1;
            span_bus.ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // Monitor: predict on request beats, check span beats, track registers.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            shape_taken <= 1'b0;
            idle_cycles <= 0;
            errors <= 0;
            shapes_sent <= 0;
            spans_seen <= 0;
            filled_spans <= 0;
            cfg_writes <= 0;
            scr_w <= 13'd640;
            scr_h <= 13'd480;
            pitch <= 16'd2560;
            red_sh <= 5'd16;
            green_sh <= 5'd8;
            blue_sh <= 5'd0;
        end
        else
        begin
            shape_taken <= shape_bus.valid && shape_bus.ready;
            if (shape_bus.valid && shape_bus.ready)
            begin
                expected_spans.push_back(row_span({shape_bus.opcode, shape_bus.center_x,
                    shape_bus.center_y, shape_bus.extent_x, shape_bus.extent_y,
                    shape_bus.row, shape_bus.red, shape_bus.green, shape_bus.blue}));
                shapes_sent <= shapes_sent + 1;
            end
            if (span_bus.valid && span_bus.ready)
            begin
                span_t got;
                span_t want;
                got = {span_bus.span_valid, span_bus.start_address,
                       span_bus.span_length, span_bus.pixel_word};
                spans_seen <= spans_seen + 1;
                if (got.span_valid)
                    filled_spans <= filled_spans + 1;
                if (expected_spans.size() == 0)
                begin
                    $display("%0t: span beat with none expected: %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_spans.pop_front();
                    if (got.span_valid !== want.span_valid)
                        $display("%0t: span_valid expected %0d got %0d", $time,
                                 want.span_valid, got.span_valid);
                    if (got.start_address !== want.start_address)
                        $display("%0t: start_address expected %0d got %0d", $time,
                                 want.start_address, got.start_address);
                    if (got.span_length !== want.span_length)
                        $display("%0t: span_length expected %0d got %0d", $time,
                                 want.span_length, got.span_length);
                    if (got.pixel_word !== want.pixel_word)
                        $display("%0t: pixel_word expected %h got %h", $time,
                                 want.pixel_word, got.pixel_word);
                    if (got !== want)
                        errors <= errors + 1;
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                cfg_writes <= cfg_writes + 1;
                case (cfg_bus.index)
                    sfrs_pkg::REG_SCREEN_WIDTH:  scr_w <= cfg_bus.data[12:0];
                    sfrs_pkg::REG_SCREEN_HEIGHT: scr_h <= cfg_bus.data[12:0];
                    sfrs_pkg::REG_ROW_PITCH:     pitch <= cfg_bus.data;
                    sfrs_pkg::REG_RED_POS:       red_sh <= cfg_bus.data[4:0];
                    sfrs_pkg::REG_GREEN_POS:     green_sh <= cfg_bus.data[4:0];
                    sfrs_pkg::REG_BLUE_POS:      blue_sh <= cfg_bus.data[4:0];
                    default: ;
                endcase
            end
            // Watchdog over cycles with work outstanding and no beat taken.
            if ((shape_bus.valid && shape_bus.ready) || (span_bus.valid && span_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)
                || (pending_shapes.size() == 0 && expected_spans.size() == 0
                    && !shape_bus.valid && !cfg_bus.valid))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_all(int w, int h, int p, int r, int g, int b);
        write_reg(sfrs_pkg::REG_SCREEN_WIDTH, 16'(w));
        write_reg(sfrs_pkg::REG_SCREEN_HEIGHT, 16'(h));
        write_reg(sfrs_pkg::REG_ROW_PITCH, 16'(p));
        write_reg(sfrs_pkg::REG_RED_POS, 16'(r));
        write_reg(sfrs_pkg::REG_GREEN_POS, 16'(g));
        write_reg(sfrs_pkg::REG_BLUE_POS, 16'(b));
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending_shapes.size() != 0 || shape_bus.valid || expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = sfrs_pkg::REG_SCREEN_WIDTH;
        cfg_bus.data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests at the reset settings.
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 320, 240, 100, 50, 240,
                                    255, 255, 255));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 0, 0, 32767, 32767, 0, 0, 0, 0));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 10, 10, 1, 1, 10, 1, 2, 3));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 10, 10, 0, 0, 10, 1, 2, 3));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, -5, 20, 30, 10, 15, 9, 8, 7));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 630, 20, 40, 10, 24, 9, 8, 7));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 100, 100, 20, 20, 110, 9, 8, 7));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 100, 100, 0, 0, 100, 40, 50, 60));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 100, 100, 1, 0, 100, 40, 50, 60));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 100, 100, 10, 0, 90, 40, 50, 60));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 100, 100, 10, 0, 109, 40, 50, 60));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 100, 100, 10, 0, 110, 40, 50, 60));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 100, 100, 10, 0, 100, 40, 50, 60));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 0, 0, 32767, 0, 0, 255, 0, 255));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, -32768, -32768, 32767, 32767,
                                    479, 255, 255, 0));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 32767, 32767, 32767, 0, 32767,
                                    0, 255, 0));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, -32768, 32767, 32767, 32767,
                                    -32768, 1, 1, 1));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 320, 0, 40, 40, -1, 5, 5, 5));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 320, 479, 40, 40, 479, 5, 5, 5));
        pending_shapes.push_back(mk(sfrs_pkg::OP_RECT, 320, 479, 40, 40, 480, 5, 5, 5));
        pending_shapes.push_back(mk(sfrs_pkg::OP_CIRCLE, 640, 200, 5, 0, 200, 5, 5, 5));
        wait_idle();

        // Random phases across register settings, extremes included.
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_all(640, 480, 2560, 16, 8, 0);
                1: set_all(4096, 4096, 32768, 24, 24, 24);
                2: set_all(8191, 8191, 65535, 31, 30, 29);
                3: set_all(1, 1, 4, 0, 0, 0);
                4: set_all(0, 0, 65535, 7, 3, 1);
                5: set_all(200, 100, 804, 20, 12, 4);
                default: set_all($urandom_range(1, 4096), $urandom_range(1, 4096),
                                 $urandom_range(4, 32768), $urandom_range(0, 31),
                                 $urandom_range(0, 31), $urandom_range(0, 31));
            endcase
            for (int i = 0; i < 62; i++)
                pending_shapes.push_back(random_shape());
            // Long receiver hold-off while the driver keeps offering beats.
            if (phase == 1)
                hold_req = 1'b1;
            wait_idle();
        end

        $display("Sent %0d shape rows over %0d register writes; %0d spans checked, %0d filled.",
                 shapes_sent, cfg_writes, spans_seen, filled_spans);
        if (errors == 0 && expected_spans.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
